### src/spr_pkg.sv
// Shared types, constants and helper functions of the stereo reprojection block.
// No dependencies; every other file of the block except spr_div imports this package.
package spr_pkg;

	localparam int RQ   = 24;
	localparam int WORD = 32;
	localparam int NUMW = 64;

	typedef enum logic [2:0] {
		REG_QUAT,
		REG_TXY,
		REG_TZ,
		REG_FOCAL,
		REG_PP,
		REG_BF,
		REG_STEREO
	} reg_idx_t;

	typedef enum logic [1:0] {
		ROW_U,
		ROW_V,
		ROW_R
	} row_idx_t;

	typedef struct packed {
		logic [8:0][29:0] rmat;
		logic [31:0]      tx;
		logic [31:0]      ty;
		logic [31:0]      tz;
		logic [31:0]      fx;
		logic [31:0]      fy;
		logic [31:0]      cx;
		logic [31:0]      cy;
		logic [31:0]      bf;
		logic             stereo;
	} cfg_t;

	typedef struct packed {
		logic [31:0] xc;
		logic [31:0] yc;
		logic [31:0] zc;
		logic [31:0] obs_u;
		logic [31:0] obs_v;
		logic [31:0] obs_r;
		logic        bad;
	} xf_t;

	typedef struct packed {
		logic [31:0] pu;
		logic [31:0] pv;
		logic [32:0] pr;
		logic [31:0] zc;
		logic [31:0] obs_u;
		logic [31:0] obs_v;
		logic [31:0] obs_r;
		logic        bad;
	} pj_t;

	typedef struct packed {
		logic [2:0]  neg;
		logic [31:0] zc;
		logic [31:0] obs_u;
		logic [31:0] obs_v;
		logic [31:0] obs_r;
		logic        bad;
	} pdiv_t;

	typedef struct packed {
		logic [2:0]  neg;
		logic [31:0] res;
		logic [1:0]  idx;
		logic        bad;
		logic        last;
	} jdiv_t;

	typedef struct packed {
		logic [1:0]  idx;
		logic [31:0] res;
		logic [31:0] jac_x;
		logic [31:0] jac_y;
		logic [31:0] jac_z;
		logic        bad;
		logic        last;
	} row_t;

	function automatic logic [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'h7fff_ffff;
		else if (v < -64'sd2147483648)
			return 32'h8000_0000;
		else
			return v[31:0];
	endfunction

	// Rotation matrix in Q24 from a Q2.14 quaternion packed w,x,y,z from the top.
	function automatic logic [8:0][29:0] quat_to_rot(input logic [63:0] q);
		logic signed [15:0] w, x, y, z;
		logic signed [31:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
		logic signed [33:0] r28 [9];
		logic signed [34:0] t;
		logic [8:0][29:0]   r;
		w  = q[63:48];
		x  = q[47:32];
		y  = q[31:16];
		z  = q[15:0];
		xx = x * x;
		yy = y * y;
		zz = z * z;
		xy = x * y;
		xz = x * z;
		yz = y * z;
		wx = w * x;
		wy = w * y;
		wz = w * z;
		r28[0] = 34'sd268435456 - 34'sd2 * (34'(yy) + 34'(zz));
		r28[1] = 34'sd2 * (34'(xy) - 34'(wz));
		r28[2] = 34'sd2 * (34'(xz) + 34'(wy));
		r28[3] = 34'sd2 * (34'(xy) + 34'(wz));
		r28[4] = 34'sd268435456 - 34'sd2 * (34'(xx) + 34'(zz));
		r28[5] = 34'sd2 * (34'(yz) - 34'(wx));
		r28[6] = 34'sd2 * (34'(xz) - 34'(wy));
		r28[7] = 34'sd2 * (34'(yz) + 34'(wx));
		r28[8] = 34'sd268435456 - 34'sd2 * (34'(xx) + 34'(yy));
		for (int i = 0; i < 9; i++) begin
			t    = 35'(r28[i]) + 35'sd8;
			r[i] = 30'(t >>> 4);
		end
		return r;
	endfunction

	localparam logic [63:0]      QUAT_RESET = 64'h4000_0000_0000_0000;
	localparam logic [8:0][29:0] RMAT_RESET = quat_to_rot(QUAT_RESET);

endpackage

### src/spr_cfg.sv
// Configuration register file with APB-style access and readback.
// Derives the Q24 rotation matrix when the quaternion is written; uses spr_pkg.
module spr_cfg import spr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output cfg_t        cfg
);

	logic [63:0]      quat_q;
	logic [8:0][29:0] rmat_q;
	logic [63:0]      txy_q;
	logic [31:0]      tz_q;
	logic [63:0]      focal_q;
	logic [63:0]      pp_q;
	logic [31:0]      bf_q;
	logic             stereo_q;
	logic             wr;
	reg_idx_t         idx;

	assign wr  = psel & penable & pwrite;
	assign idx = reg_idx_t'(paddr[5:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_q   <= QUAT_RESET;
			rmat_q   <= RMAT_RESET;
			txy_q    <= '0;
			tz_q     <= '0;
			focal_q  <= '0;
			pp_q     <= '0;
			bf_q     <= '0;
			stereo_q <= 1'b1;
		end else if (wr) begin
			unique case (idx)
				REG_QUAT: begin
					quat_q <= pwdata;
					rmat_q <= quat_to_rot(pwdata);
				end
				REG_TXY:    txy_q    <= pwdata;
				REG_TZ:     tz_q     <= pwdata[31:0];
				REG_FOCAL:  focal_q  <= pwdata;
				REG_PP:     pp_q     <= pwdata;
				REG_BF:     bf_q     <= pwdata[31:0];
				REG_STEREO: stereo_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_QUAT:   prdata = quat_q;
			REG_TXY:    prdata = txy_q;
			REG_TZ:     prdata = 64'(tz_q);
			REG_FOCAL:  prdata = focal_q;
			REG_PP:     prdata = pp_q;
			REG_BF:     prdata = 64'(bf_q);
			REG_STEREO: prdata = 64'(stereo_q);
			default:    prdata = '0;
		endcase
	end

	always_comb begin
		cfg.rmat   = rmat_q;
		cfg.tx     = txy_q[63:32];
		cfg.ty     = txy_q[31:0];
		cfg.tz     = tz_q;
		cfg.fx     = focal_q[63:32];
		cfg.fy     = focal_q[31:0];
		cfg.cx     = pp_q[63:32];
		cfg.cy     = pp_q[31:0];
		cfg.bf     = bf_q;
		cfg.stereo = stereo_q;
	end

endmodule

### src/spr_div.sv
// Pipelined restoring divider: several numerators over one shared divisor,
// one quotient bit per stage, with a side payload. Stand-alone, no package use.
module spr_div #(
	parameter int LANES = 3,
	parameter int NW    = 64,
	parameter int DW    = 32,
	parameter int QW    = 40,
	parameter int PW    = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [LANES-1:0][NW-1:0]    in_num,
	input  logic [DW-1:0]               in_den,
	input  logic [PW-1:0]               in_pay,
	output logic                        out_valid,
	output logic [LANES-1:0][QW-1:0]    out_quot,
	output logic [LANES-1:0]            out_over,
	output logic [PW-1:0]               out_pay
);

	localparam int HW = NW - QW;
	localparam int CW = (HW > DW) ? HW : DW;

	logic [QW:0]             vld_s;
	logic [DW-1:0]           den_s [QW+1];
	logic [PW-1:0]           pay_s [QW+1];
	logic [LANES-1:0][DW-1:0] rem_s [QW+1];
	logic [LANES-1:0][QW-1:0] x_s  [QW+1];
	logic [LANES-1:0]        over_s [QW+1];
	logic [LANES-1:0]        over_in;

	always_comb begin
		for (int l = 0; l < LANES; l++)
			over_in[l] = CW'(in_num[l][NW-1:QW]) >= CW'(in_den);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (en)
			vld_s <= {vld_s[QW-1:0], in_valid};
	end

	// Stage 0 loads the high part of the numerator as the first partial remainder, or zero on overflow.
	always_ff @(posedge clk) begin
		if (en) begin
			den_s[0]  <= in_den;
			pay_s[0]  <= in_pay;
			over_s[0] <= over_in;
			for (int l = 0; l < LANES; l++) begin
				rem_s[0][l] <= over_in[l] ? '0 : DW'(in_num[l][NW-1:QW]);
				x_s[0][l]   <= in_num[l][QW-1:0];
			end
		end
	end

	for (genvar j = 0; j < QW; j++) begin : g_step
		logic [LANES-1:0][DW:0] t;
		logic [LANES-1:0]       ge;

		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				t[l]  = {rem_s[j][l], x_s[j][l][QW-1]};
				ge[l] = t[l] >= {1'b0, den_s[j]};
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[j+1]  <= den_s[j];
				pay_s[j+1]  <= pay_s[j];
				over_s[j+1] <= over_s[j];
				for (int l = 0; l < LANES; l++) begin
					rem_s[j+1][l] <= ge[l] ? DW'(t[l] - {1'b0, den_s[j]}) : t[l][DW-1:0];
					x_s[j+1][l]   <= {x_s[j][l][QW-2:0], ge[l]};
				end
			end
		end
	end

	assign out_valid = vld_s[QW];
	assign out_quot  = x_s[QW];
	assign out_over  = over_s[QW];
	assign out_pay   = pay_s[QW];

endmodule

### src/spr_xform.sv
// Rigid transform of the world point into the camera frame, four register stages.
// Uses spr_pkg for the configuration bundle and saturation helper.
module spr_xform import spr_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         in_valid,
	input  logic [191:0] in_data,
	input  cfg_t         cfg,
	output logic         out_valid,
	output xf_t          out_xf
);

	logic                v_s1, v_s2, v_s3, v_s4;
	logic signed [31:0]  pt_s1 [3];
	logic [95:0]         obs_s1, obs_s2, obs_s3;
	logic signed [61:0]  prod_s2 [9];
	logic signed [63:0]  acc_s3 [3];
	xf_t                 xf_s4;
	logic signed [63:0]  rs [3];
	logic signed [63:0]  ts [3];
	logic signed [31:0]  tv [3];
	logic [31:0]         c [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign tv[0] = $signed(cfg.tx);
	assign tv[1] = $signed(cfg.ty);
	assign tv[2] = $signed(cfg.tz);

	// Round the Q24 sum to nearest, ties upward, then add the translation.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rs[i] = (acc_s3[i] + (64'sd1 <<< (RQ - 1))) >>> RQ;
			ts[i] = rs[i] + 64'(tv[i]);
			c[i]  = sat32(ts[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pt_s1[0] <= $signed(in_data[31:0]);
			pt_s1[1] <= $signed(in_data[63:32]);
			pt_s1[2] <= $signed(in_data[95:64]);
			obs_s1   <= in_data[191:96];
			for (int i = 0; i < 3; i++)
				for (int k = 0; k < 3; k++)
					prod_s2[3*i+k] <= 62'($signed(cfg.rmat[3*i+k])) * 62'(pt_s1[k]);
			obs_s2 <= obs_s1;
			for (int i = 0; i < 3; i++)
				acc_s3[i] <= 64'(prod_s2[3*i]) + 64'(prod_s2[3*i+1]) + 64'(prod_s2[3*i+2]);
			obs_s3 <= obs_s2;
			xf_s4.xc    <= c[0];
			xf_s4.yc    <= c[1];
			xf_s4.zc    <= c[2];
			xf_s4.bad   <= $signed(c[2]) <= 32'sd0;
			xf_s4.obs_u <= obs_s3[31:0];
			xf_s4.obs_v <= obs_s3[63:32];
			xf_s4.obs_r <= obs_s3[95:64];
		end
	end

	assign out_valid = v_s4;
	assign out_xf    = xf_s4;

endmodule

### src/spr_proj.sv
// Pinhole projection: fx*xc/zc, fy*yc/zc and disparity through a shared-divisor
// divider pipeline. Uses spr_pkg and spr_div.
module spr_proj import spr_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  xf_t  in_xf,
	input  cfg_t cfg,
	output logic out_valid,
	output pj_t  out_pj
);

	localparam int RS = RQ - FRAC_BITS;
	localparam int QW = WORD + RS;

	logic                     v_s5, v_s6, v_s7;
	logic signed [63:0]       n_s5 [3];
	xf_t                      xf_s5;
	logic [2:0][63:0]         mag_s6;
	pdiv_t                    pay_s6;
	pj_t                      pj_s7;
	logic                     dv;
	logic [2:0][QW-1:0]       dq;
	logic [2:0]               dover;
	logic [$bits(pdiv_t)-1:0] dpay_raw;
	pdiv_t                    dpay;
	logic [63:0]              m [3];
	logic signed [63:0]       sv [3];
	logic [31:0]              sq [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s5 <= in_valid;
			v_s6 <= v_s5;
			v_s7 <= dv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s5[0] <= $signed({32'b0, cfg.fx}) * 64'($signed(in_xf.xc));
			n_s5[1] <= $signed({32'b0, cfg.fy}) * 64'($signed(in_xf.yc));
			n_s5[2] <= $signed(64'(cfg.bf) << FRAC_BITS);
			xf_s5   <= in_xf;
			for (int k = 0; k < 3; k++) begin
				mag_s6[k]     <= n_s5[k][63] ? 64'(-n_s5[k]) : 64'(n_s5[k]);
				pay_s6.neg[k] <= n_s5[k][63];
			end
			pay_s6.zc    <= xf_s5.zc;
			pay_s6.obs_u <= xf_s5.obs_u;
			pay_s6.obs_v <= xf_s5.obs_v;
			pay_s6.obs_r <= xf_s5.obs_r;
			pay_s6.bad   <= xf_s5.bad;
		end
	end

	spr_div #(
		.LANES(3),
		.NW   (NUMW),
		.DW   (WORD),
		.QW   (QW),
		.PW   ($bits(pdiv_t))
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s6),
		.in_num   (mag_s6),
		.in_den   (pay_s6.zc),
		.in_pay   (pay_s6),
		.out_valid(dv),
		.out_quot (dq),
		.out_over (dover),
		.out_pay  (dpay_raw)
	);

	assign dpay = pdiv_t'(dpay_raw);

	// Quotients are truncated toward zero; an overflowing one saturates.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			m[k]  = dover[k] ? (64'd1 << QW) : 64'(dq[k]);
			sv[k] = dpay.neg[k] ? -$signed(m[k]) : $signed(m[k]);
			sq[k] = sat32(sv[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pj_s7.pu    <= sq[0];
			pj_s7.pv    <= sq[1];
			pj_s7.pr    <= 33'($signed(sq[0])) - 33'($signed(sq[2]));
			pj_s7.zc    <= dpay.zc;
			pj_s7.obs_u <= dpay.obs_u;
			pj_s7.obs_v <= dpay.obs_v;
			pj_s7.obs_r <= dpay.obs_r;
			pj_s7.bad   <= dpay.bad;
		end
	end

	assign out_valid = v_s7;
	assign out_pj    = pj_s7;

endmodule

### src/spr_jac.sv
// Row expander and per-row residual and Jacobian pipeline, one row per cycle while en is high.
// Uses spr_pkg and a second spr_div for the Jacobian quotients.
module spr_jac import spr_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  pj_t  in_pj,
	input  cfg_t cfg,
	output logic in_ready,
	output logic out_valid,
	output row_t out_row
);

	localparam int RS = RQ - FRAC_BITS;
	localparam int QW = WORD + RS;
	localparam logic signed [63:0] HALF = (64'sd1 <<< RS) >>> 1;

	logic                     x_valid_q;
	pj_t                      x_q;
	logic [1:0]               row_q;
	logic                     last_row;
	logic                     take;

	logic [31:0]              f_c, c_c, obs_c;
	logic [32:0]              p_c;
	logic [2:0][29:0]         rr_c;

	logic                     v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [1:0]               idx_s1, idx_s2, idx_s3;
	logic                     last_s1, last_s2, last_s3;
	logic                     bad_s1, bad_s2, bad_s3;
	logic [31:0]              f_s1, c_s1, obs_s1, zc_s1, zc_s2, zc_s3;
	logic [32:0]              p_s1;
	logic [2:0][29:0]         rr_s1;
	logic signed [63:0]       a_s2 [3];
	logic signed [63:0]       b_s2 [3];
	logic [31:0]              res_s2, res_s3;
	logic signed [63:0]       num_s3 [3];
	logic [2:0][63:0]         mag_s4;
	jdiv_t                    pay_s4;
	logic [31:0]              zc_s4;
	row_t                     row_s5;

	logic                     dv;
	logic [2:0][QW-1:0]       dq;
	logic [2:0]               dover;
	logic [$bits(jdiv_t)-1:0] dpay_raw;
	jdiv_t                    dpay;
	logic [63:0]              m [3];
	logic signed [63:0]       sv [3];
	logic signed [63:0]       rnd [3];
	logic [31:0]              jq [3];

	// The right-u row always closes an item, even if the mode changed under it.
	assign last_row = (row_q == ROW_R) || (!cfg.stereo && row_q == ROW_V);
	assign take     = !x_valid_q || last_row;
	assign in_ready = en && take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_valid_q <= 1'b0;
			row_q     <= ROW_U;
		end else if (en) begin
			if (take) begin
				x_valid_q <= in_valid;
				row_q     <= ROW_U;
			end else begin
				row_q <= row_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && take)
			x_q <= in_pj;
	end

	always_comb begin
		unique case (row_q)
			ROW_U: begin
				f_c   = cfg.fx;
				rr_c  = cfg.rmat[2:0];
				p_c   = 33'($signed(x_q.pu));
				c_c   = cfg.cx;
				obs_c = x_q.obs_u;
			end
			ROW_V: begin
				f_c   = cfg.fy;
				rr_c  = cfg.rmat[5:3];
				p_c   = 33'($signed(x_q.pv));
				c_c   = cfg.cy;
				obs_c = x_q.obs_v;
			end
			default: begin
				f_c   = cfg.fx;
				rr_c  = cfg.rmat[2:0];
				p_c   = x_q.pr;
				c_c   = cfg.cx;
				obs_c = x_q.obs_r;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= x_valid_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= dv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s1  <= row_q;
			last_s1 <= last_row;
			bad_s1  <= x_q.bad;
			f_s1    <= f_c;
			c_s1    <= c_c;
			obs_s1  <= obs_c;
			p_s1    <= p_c;
			rr_s1   <= rr_c;
			zc_s1   <= x_q.zc;

			for (int k = 0; k < 3; k++) begin
				a_s2[k] <= $signed({32'b0, f_s1}) * 64'($signed(rr_s1[k]));
				b_s2[k] <= 64'($signed(p_s1)) * 64'($signed(cfg.rmat[6+k]));
			end
			res_s2  <= sat32(64'($signed(obs_s1))
				- (64'($signed(p_s1)) + $signed({32'b0, c_s1})));
			idx_s2  <= idx_s1;
			last_s2 <= last_s1;
			bad_s2  <= bad_s1;
			zc_s2   <= zc_s1;

			for (int k = 0; k < 3; k++)
				num_s3[k] <= b_s2[k] - a_s2[k];
			res_s3  <= res_s2;
			idx_s3  <= idx_s2;
			last_s3 <= last_s2;
			bad_s3  <= bad_s2;
			zc_s3   <= zc_s2;

			for (int k = 0; k < 3; k++) begin
				mag_s4[k]     <= num_s3[k][63] ? 64'(-num_s3[k]) : 64'(num_s3[k]);
				pay_s4.neg[k] <= num_s3[k][63];
			end
			pay_s4.res  <= res_s3;
			pay_s4.idx  <= idx_s3;
			pay_s4.bad  <= bad_s3;
			pay_s4.last <= last_s3;
			zc_s4       <= zc_s3;
		end
	end

	spr_div #(
		.LANES(3),
		.NW   (NUMW),
		.DW   (WORD),
		.QW   (QW),
		.PW   ($bits(jdiv_t))
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s4),
		.in_num   (mag_s4),
		.in_den   (zc_s4),
		.in_pay   (pay_s4),
		.out_valid(dv),
		.out_quot (dq),
		.out_over (dover),
		.out_pay  (dpay_raw)
	);

	assign dpay = jdiv_t'(dpay_raw);

	// Truncated Q24 quotient, then rounded to nearest, ties upward, to the output fraction width.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			m[k]   = dover[k] ? (64'd1 << QW) : 64'(dq[k]);
			sv[k]  = dpay.neg[k] ? -$signed(m[k]) : $signed(m[k]);
			rnd[k] = (sv[k] + HALF) >>> RS;
			jq[k]  = sat32(rnd[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			row_s5.idx   <= dpay.idx;
			row_s5.bad   <= dpay.bad;
			row_s5.last  <= dpay.last;
			row_s5.res   <= dpay.bad ? '0 : dpay.res;
			row_s5.jac_x <= dpay.bad ? '0 : jq[0];
			row_s5.jac_y <= dpay.bad ? '0 : jq[1];
			row_s5.jac_z <= dpay.bad ? '0 : jq[2];
		end
	end

	assign out_valid = v_s5;
	assign out_row   = row_s5;

endmodule

### src/stereo_projection_residual_jacobian.sv
// Stereo pinhole reprojection residual and point Jacobian, top level.
// Holds the two-entry result buffer; uses spr_pkg, spr_cfg, spr_xform, spr_proj and spr_jac.
//
// A point request enters on the s_ side and produces two rows (mono) or three rows
// (stereo) on the m_ side, in row order u, v, right u, the final one flagged by
// m_tlast. The block takes a new point only while the row expander is empty or
// sending its last row, since all rows of all points leave through the single result
// channel and the row expander holds a point until its last row has left. Inside,
// the pipeline moves one step per cycle while not stalled, through the transform,
// the projection divider, the row expander and the Jacobian divider; the dividers
// retire one quotient bit per stage. A two-entry buffer sits at the output, so a
// new request is still taken while one finished row waits. The user must write registers
// through the APB-style port only while no point is in flight; the block does not enforce it.
module stereo_projection_residual_jacobian import spr_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [5:0]   paddr,
	input  logic [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready,
	input  logic         s_tvalid,
	output logic         s_tready,
	// point_x, point_y, point_z, obs_u, obs_v, obs_right_u, 32 bits each
	input  logic [191:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// residual, jac_x, jac_y, jac_z, 32 bits each
	output logic [127:0] m_tdata,
	// row_index [1:0], depth_invalid [2]
	output logic [2:0]   m_tuser,
	output logic         m_tlast
);

	cfg_t       cfg;
	logic       en;
	logic       xf_valid;
	xf_t        xf;
	logic       pj_valid;
	pj_t        pj;
	logic       row_valid;
	row_t       row;
	row_t       buf_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;
	row_t       head;

	assign pready = 1'b1;

	spr_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.cfg    (cfg)
	);

	// u_jac advances while the output buffer has room, u_xform and u_proj on s_tready.
	assign en = cnt_q != 2'd2;

	spr_xform u_xform (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (s_tready),
		.in_valid (s_tvalid),
		.in_data  (s_tdata),
		.cfg      (cfg),
		.out_valid(xf_valid),
		.out_xf   (xf)
	);

	spr_proj #(.FRAC_BITS(FRAC_BITS)) u_proj (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (s_tready),
		.in_valid (xf_valid),
		.in_xf    (xf),
		.cfg      (cfg),
		.out_valid(pj_valid),
		.out_pj   (pj)
	);

	spr_jac #(.FRAC_BITS(FRAC_BITS)) u_jac (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (pj_valid),
		.in_pj    (pj),
		.cfg      (cfg),
		.in_ready (s_tready),
		.out_valid(row_valid),
		.out_row  (row)
	);

	assign push = en && row_valid;
	assign pop  = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			buf_q[wr_ptr_q] <= row;
	end

	assign head     = buf_q[rd_ptr_q];
	assign m_tvalid = cnt_q != 2'd0;
	assign m_tdata  = {head.jac_z, head.jac_y, head.jac_x, head.res};
	assign m_tuser  = {head.bad, head.idx};
	assign m_tlast  = head.last;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result buffer count out of range");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> m_tdata == '0)
		else $error("row with depth_invalid carries nonzero data");

	a_right_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1:0] == ROW_R |-> m_tlast)
		else $error("right u row not marked as last");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !s_tready)
		else $error("request taken while the result buffer is full");

endmodule
